>>> sv/wsdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsdf_pkg
// shared types and constants of the websocket frame deframer
// ----------------------------------------------------------------------------
package wsdf_pkg;

   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 64;
   localparam int KEY_W   = 32;
   localparam int COUNT_W = 4;
   localparam int KIDX_W  = 2;

   // second header byte fields
   localparam logic [BYTE_W-1:0] MASK_BIT   = 8'h80;
   localparam logic [BYTE_W-1:0] LEN_MASK   = 8'h7F;
   localparam logic [BYTE_W-1:0] LEN16_CODE = 8'd126;
   localparam logic [BYTE_W-1:0] LEN64_CODE = 8'd127;

   // extended length and key byte counts
   localparam logic [COUNT_W-1:0] LEN16_BYTES = 4'd2;
   localparam logic [COUNT_W-1:0] LEN64_BYTES = 4'd8;
   localparam logic [COUNT_W-1:0] KEY_BYTES   = 4'd4;

   typedef enum logic [5:0] {
      PH_FIRST   = 6'b000001,
      PH_SECOND  = 6'b000010,
      PH_EXTLEN  = 6'b000100,
      PH_KEY     = 6'b001000,
      PH_PAYLOAD = 6'b010000,
      PH_DROP    = 6'b100000
   } phase_type;

endpackage

>>> sv/websocket_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// strips the header of a received frame and unmasks its payload bytes
// ----------------------------------------------------------------------------
// One byte of the received buffer enters per beat on the req_ side; req_tlast
// marks the last byte of the buffer. The first header byte is skipped, the
// second gives the mask bit and the 7-bit length, 126 or 127 pull in a 16 or
// 64-bit big-endian length, and a set mask bit pulls in the 4-byte key. Each
// payload byte leaves on the rsp_ side XORed with its key byte; rsp_tlast
// flags the last payload byte, or the payload byte that ended the buffer.
// Header bytes and bytes past the payload produce no beat. Payload bytes go
// from the header parser into the result register, so the block accepts
// one beat per cycle while req_tready is high. A two-deep output stage
// (result register and skid register) keeps req_tready high while one result
// waits; req_tready drops only while both are full. All parser state returns
// to the start after the byte that carries req_tlast.
module websocket_frame_deframer (
   input  logic                          clock,
   input  logic                          reset,
   // input beats
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [wsdf_pkg::BYTE_W-1:0]   req_tdata,   // [7:0] rx_byte
   input  logic                          req_tlast,   // end_of_buffer
   // result beats
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [wsdf_pkg::BYTE_W-1:0]   rsp_tdata,   // [7:0] payload_byte
   output logic                          rsp_tlast    // last_of_message
);
   import wsdf_pkg::*;

   // parser state
   phase_type            phase_ff, phase_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 masked_ff, masked_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [LEN_W-1:0]     remain_ff, remain_in;   // payload bytes still to come
   logic [KIDX_W-1:0]    kidx_ff, kidx_in;       // payload index mod 4

   // output stage
   logic                 out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]    out_byte_ff, out_byte_in;
   logic                 out_last_ff, out_last_in;
   logic                 skid_valid_ff, skid_valid_in;
   logic [BYTE_W-1:0]    skid_byte_ff, skid_byte_in;
   logic                 skid_last_ff, skid_last_in;

   logic                 accept;
   logic                 out_take;
   logic                 res_valid;
   logic [BYTE_W-1:0]    res_byte;
   logic                 res_last;
   logic [BYTE_W-1:0]    key_byte;
   logic [BYTE_W-1:0]    len7;
   logic [LEN_W-1:0]     ext_len;
   logic [LEN_W-1:0]     remain_dec;
   logic [COUNT_W-1:0]   count_dec;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign out_take   = out_valid_ff && rsp_tready;

   assign len7       = req_tdata & LEN_MASK;
   assign ext_len    = {remain_ff[LEN_W-BYTE_W-1:0], req_tdata};
   assign remain_dec = remain_ff - LEN_W'(1);
   assign count_dec  = count_ff - COUNT_W'(1);

   // key byte for this payload index, first key byte in the top byte
   always_comb begin
      case (kidx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // header parser and payload unmasking
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      masked_in = masked_ff;
      key_in    = key_ff;
      remain_in = remain_ff;
      kidx_in   = kidx_ff;
      res_valid = 1'b0;
      res_byte  = req_tdata ^ (masked_ff ? key_byte : '0);
      res_last  = req_tlast || (remain_ff == LEN_W'(1));

      if (accept) begin
         case (phase_ff)
            PH_FIRST: begin
               phase_in = PH_SECOND;
            end
            PH_SECOND: begin
               masked_in = (req_tdata & MASK_BIT) != '0;
               if (len7 == LEN16_CODE) begin
                  remain_in = '0;
                  count_in  = LEN16_BYTES;
                  phase_in  = PH_EXTLEN;
               end else if (len7 == LEN64_CODE) begin
                  remain_in = '0;
                  count_in  = LEN64_BYTES;
                  phase_in  = PH_EXTLEN;
               end else begin
                  remain_in = LEN_W'(len7);
                  if (masked_in) begin
                     phase_in = PH_KEY;
                     count_in = KEY_BYTES;
                  end else begin
                     phase_in = (len7 != '0) ? PH_PAYLOAD : PH_DROP;
                  end
               end
            end
            PH_EXTLEN: begin
               remain_in = ext_len;
               count_in  = count_dec;
               if (count_dec == '0) begin
                  if (masked_ff) begin
                     phase_in = PH_KEY;
                     count_in = KEY_BYTES;
                  end else begin
                     phase_in = (ext_len != '0) ? PH_PAYLOAD : PH_DROP;
                  end
               end
            end
            PH_KEY: begin
               key_in   = {key_ff[KEY_W-BYTE_W-1:0], req_tdata};
               count_in = count_dec;
               if (count_dec == '0) begin
                  phase_in = (remain_ff != '0) ? PH_PAYLOAD : PH_DROP;
               end
            end
            PH_PAYLOAD: begin
               res_valid = 1'b1;
               remain_in = remain_dec;
               kidx_in   = kidx_ff + KIDX_W'(1);
               // one byte left means this is the final payload byte
               if (remain_ff == LEN_W'(1)) begin
                  phase_in = PH_DROP;
               end
            end
            default: begin
               // drop phase and unused codes: bytes are discarded
            end
         endcase

         // end of buffer: back to the start
         if (req_tlast) begin
            phase_in  = PH_FIRST;
            count_in  = '0;
            masked_in = 1'b0;
            key_in    = '0;
            remain_in = '0;
            kidx_in   = '0;
         end
      end
   end

   // result register with skid stage behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      skid_valid_in = skid_valid_ff;
      skid_byte_in  = skid_byte_ff;
      skid_last_in  = skid_last_ff;
      if (skid_valid_ff) begin
         // no beat accepted here, ready is low
         if (out_take) begin
            out_byte_in   = skid_byte_ff;
            out_last_in   = skid_last_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || out_take) begin
            out_valid_in = 1'b1;
            out_byte_in  = res_byte;
            out_last_in  = res_last;
         end else begin
            skid_valid_in = 1'b1;
            skid_byte_in  = res_byte;
            skid_last_in  = res_last;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_FIRST;
         count_ff      <= '0;
         masked_ff     <= 1'b0;
         key_ff        <= '0;
         remain_ff     <= '0;
         kidx_ff       <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         masked_ff     <= masked_in;
         key_ff        <= key_in;
         remain_ff     <= remain_in;
         kidx_ff       <= kidx_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      skid_byte_ff <= skid_byte_in;
      skid_last_ff <= skid_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

>>> sv/wsdf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsdf_checker
// port-level checks of the websocket frame deframer, bound to the top level
// ----------------------------------------------------------------------------
module wsdf_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [wsdf_pkg::BYTE_W-1:0]   req_tdata,
   input  logic                          req_tlast,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [wsdf_pkg::BYTE_W-1:0]   rsp_tdata,
   input  logic                          rsp_tlast
);
   import wsdf_pkg::*;

   // a stalled result beat holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // a result beat appears only after an input beat was taken
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result beat without an input beat");

   // input is held off only while a result waits at the output
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with empty output");

   // with the output idle and nothing taken, the output stays idle
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !(req_tvalid && req_tready) |=> !rsp_tvalid)
      else $error("result beat from nowhere");

endmodule

bind websocket_frame_deframer wsdf_checker u_wsdf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
